[rtl/core/fdcr_pkg.sv]
`default_nettype none

package fdcr_pkg;

   // number of disks served in turn
   localparam int DISKS = 2;

   // port widths of the item and result fields
   localparam int MODE_W     = 3;
   localparam int DESC_W     = 8;
   localparam int OFFSET_W   = 48;
   localparam int COUNT_W    = 32;
   localparam int WHENCE_W   = 2;
   localparam int KIND_W     = 2;
   localparam int OUT_POS_W  = 48;
   localparam int LEN_W      = 31;
   localparam int DESC_RANGE = 1 << DESC_W;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // call modes
   localparam logic [MODE_W-1:0] MODE_PREAD  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PWRITE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLOSE  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SEEK   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_END    = 3'd6;
   localparam logic [MODE_W-1:0] MODE_OTHER  = 3'd7;

   // seek origins
   localparam logic [WHENCE_W-1:0] WHENCE_SET = 2'd0;
   localparam logic [WHENCE_W-1:0] WHENCE_CUR = 2'd1;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

   // operations carried from front to back
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
   localparam logic [OP_W-1:0] OP_PPOS   = 3'd1;
   localparam logic [OP_W-1:0] OP_STREAM = 3'd2;
   localparam logic [OP_W-1:0] OP_CLOSE  = 3'd3;
   localparam logic [OP_W-1:0] OP_SEEK   = 3'd4;
   localparam logic [OP_W-1:0] OP_END    = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic                is_write;
      logic [WHENCE_W-1:0] whence;
   } op_ctrl_type;

   localparam int CTRL_W = $bits(op_ctrl_type);

endpackage

`default_nettype wire

[rtl/core/fdcr_ram.sv]
`default_nettype none

module fdcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/core/fdcr_front.sv]
`default_nettype none

module fdcr_front
   import fdcr_pkg::*;
#(
   parameter int FD_SLOTS = 256,
   parameter int POS_BITS = 48
) (
   input  wire logic                        accept,
   input  wire logic [MODE_W-1:0]           req_mode,
   input  wire logic [DESC_W-1:0]           req_descriptor,
   input  wire logic signed [OFFSET_W-1:0]  req_offset,
   input  wire logic signed [COUNT_W-1:0]   req_byte_count,
   input  wire logic [WHENCE_W-1:0]         req_whence,
   output logic                             push,
   output op_ctrl_type                      ctrl,
   output logic [$clog2(FD_SLOTS)-1:0]      fd,
   output logic [POS_BITS-1:0]              off,
   output logic [LEN_W-1:0]                 cnt
);

   localparam int FdW = $clog2(FD_SLOTS);

   logic [FdW-1:0]    fd_map [DESC_RANGE];
   logic signed [63:0] off_wide;
   logic              negative;

   // descriptor folded into the table, worked out at elaboration
   for (genvar g = 0; g < DESC_RANGE; g++) begin : g_fd_map
      assign fd_map[g] = FdW'(g % FD_SLOTS);
   end

   assign fd       = fd_map[req_descriptor];
   assign off_wide = 64'(req_offset);
   assign off      = off_wide[POS_BITS-1:0];
   assign negative = req_byte_count[COUNT_W-1];
   assign cnt      = req_byte_count[LEN_W-1:0];

   always_comb begin
      ctrl.op       = OP_NONE;
      ctrl.is_write = req_mode[0];
      ctrl.whence   = req_whence;
      unique case (req_mode)
         MODE_PREAD, MODE_PWRITE: begin
            ctrl.op = negative ? OP_NONE : OP_PPOS;
         end
         MODE_READ, MODE_WRITE: begin
            ctrl.op = negative ? OP_NONE : OP_STREAM;
         end
         MODE_CLOSE: ctrl.op = OP_CLOSE;
         MODE_SEEK:  ctrl.op = OP_SEEK;
         MODE_END:   ctrl.op = OP_END;
         MODE_OTHER: ctrl.op = OP_NONE;
         default:    ctrl.op = OP_NONE;
      endcase
   end

   // skipped calls never reach the queue
   assign push = accept && (ctrl.op != OP_NONE);

endmodule

`default_nettype wire

[rtl/core/fdcr_queue.sv]
`default_nettype none

module fdcr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] head,
   output logic                  empty,
   output logic                  full
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FullCnt);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/core/fdcr_back.sv]
`default_nettype none

module fdcr_back
   import fdcr_pkg::*;
#(
   parameter int FD_SLOTS = 256,
   parameter int POS_BITS = 48
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      q_empty,
   input  wire logic [CTRL_W+$clog2(FD_SLOTS)+POS_BITS+LEN_W-1:0] q_head,
   output logic                                           q_pop,
   output logic                                           clearing,
   output logic                                           rsp_valid,
   output logic [KIND_W-1:0]                              rsp_request_kind,
   output logic                                           rsp_disk,
   output logic [OUT_POS_W-1:0]                           rsp_position,
   output logic [LEN_W-1:0]                               rsp_length
);

   localparam int FdW   = $clog2(FD_SLOTS);
   localparam int Depth = DISKS * FD_SLOTS;
   localparam int AddrW = $clog2(Depth);
   localparam int WordW = POS_BITS + 1;
   localparam logic [AddrW-1:0] LastAddr  = AddrW'(Depth - 1);
   localparam logic [AddrW-1:0] DiskStride = AddrW'(FD_SLOTS);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                 state_ff, state_in;
   logic                 clr_ff, clr_in;
   logic [AddrW-1:0]     clr_addr_ff, clr_addr_in;
   logic                 disk_ff, disk_in;
   op_ctrl_type          ctrl_ff;
   logic [POS_BITS-1:0]  off_ff;
   logic [LEN_W-1:0]     cnt_ff;
   logic [AddrW-1:0]     addr_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic                 rsp_disk_ff;
   logic [OUT_POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;

   op_ctrl_type          head_ctrl;
   logic [FdW-1:0]       head_fd;
   logic [POS_BITS-1:0]  head_off;
   logic [LEN_W-1:0]     head_cnt;
   logic [AddrW-1:0]     rd_addr;

   logic                 ram_we;
   logic [AddrW-1:0]     ram_waddr;
   logic [WordW-1:0]     ram_wdata;
   logic [WordW-1:0]     ram_rdata;

   logic [POS_BITS-1:0]  tbl_pos;
   logic [POS_BITS-1:0]  add_a, add_b, sum;
   logic [POS_BITS-1:0]  cnt_ext;
   logic [POS_BITS-1:0]  new_pos;
   logic                 new_valid;
   logic                 exec;
   logic                 emits;
   logic [POS_BITS-1:0]  emit_pos;

   assign {head_ctrl, head_fd, head_off, head_cnt} = q_head;

   // entry address: disk selects the half, descriptor the slot
   assign rd_addr = (disk_ff ? DiskStride : '0) + AddrW'(head_fd);

   assign q_pop    = (state_ff == ST_IDLE) && !clr_ff && !q_empty;
   assign clearing = clr_ff;
   assign exec     = (state_ff == ST_EXEC);

   fdcr_ram #(
      .WIDTH (WordW),
      .DEPTH (Depth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // missing entry reads as position zero
   assign tbl_pos = ram_rdata[POS_BITS] ? ram_rdata[POS_BITS-1:0] : '0;
   assign cnt_ext = POS_BITS'(cnt_ff);

   always_comb begin
      add_a = (ctrl_ff.op == OP_STREAM) ? tbl_pos : off_ff;
      add_b = (ctrl_ff.op == OP_SEEK) ? tbl_pos : cnt_ext;
   end

   assign sum = add_a + add_b;

   always_comb begin
      new_pos   = sum;
      new_valid = 1'b1;
      emits     = 1'b0;
      emit_pos  = '0;
      case (ctrl_ff.op)
         OP_PPOS: begin
            emits    = 1'b1;
            emit_pos = off_ff;
         end
         OP_STREAM: begin
            emits    = 1'b1;
            emit_pos = tbl_pos;
         end
         OP_CLOSE: begin
            new_pos   = '0;
            new_valid = 1'b0;
         end
         OP_SEEK: begin
            case (ctrl_ff.whence)
               WHENCE_SET: new_pos = off_ff;
               WHENCE_CUR: new_pos = sum;
               default:    new_pos = '0;
            endcase
         end
         OP_END: begin
            emits = 1'b1;
         end
         default: begin
            new_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      ram_we    = clr_ff || (exec && ctrl_ff.op != OP_END);
      ram_waddr = clr_ff ? clr_addr_ff : addr_ff;
      ram_wdata = clr_ff ? '0 : {new_valid, new_pos};
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_addr_in  = clr_addr_ff;
      disk_in      = disk_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = (ctrl_ff.op == OP_END) ? KIND_END
                                            : (ctrl_ff.is_write ? KIND_WRITE : KIND_READ);
      rsp_pos_in   = OUT_POS_W'(emit_pos);
      rsp_len_in   = (ctrl_ff.op == OP_END) ? '0 : cnt_ff;
      if (clr_ff) begin
         if (clr_addr_ff == LastAddr) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (emits) begin
               rsp_valid_in = 1'b1;
               disk_in      = !disk_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         disk_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         disk_ff      <= disk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ctrl_ff <= head_ctrl;
         off_ff  <= head_off;
         cnt_ff  <= head_cnt;
         addr_ff <= rd_addr;
      end
      if (exec && emits) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_disk_ff <= disk_ff;
         rsp_pos_ff  <= rsp_pos_in;
         rsp_len_ff  <= rsp_len_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_request_kind = rsp_kind_ff;
   assign rsp_disk         = rsp_disk_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_length       = rsp_len_ff;

endmodule

`default_nettype wire

[rtl/core/file_call_to_disk_request_top.sv]
// File call to disk request converter. A traced file call is taken at a rising
// edge with start high and busy low; each call that makes a disk request
// (positioned or stream read/write with a non-negative count, or end of trace)
// gives one result, shown on the rsp_ ports for a single cycle with rsp_valid
// high. The receiver cannot hold results off, so it must take every strobe.
// After reset, busy stays high while the position table memory is swept clear.
// A front stage classifies calls into a two-entry queue; the back end handles
// one queued call at a time, addressing the table memory as it pops a call in
// its idle state, then updating the table and registering the result in its
// exec state; it takes no new call before it is back in idle, and busy rises
// when the queue fills. On an idle block a call passes the queue, the operand
// registers and the result register before its strobe. Close and seek update
// the table in order but raise no strobe; other calls and reads or writes with
// a negative count are dropped at the front and change nothing. Requests
// alternate between the two disks, starting with disk 0 after reset.
`default_nettype none

module file_call_to_disk_request_top
   import fdcr_pkg::*;
#(
   parameter int FD_SLOTS = 256,
   parameter int POS_BITS = 48
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // item in
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [MODE_W-1:0]           req_mode,
   input  wire logic [DESC_W-1:0]           req_descriptor,
   input  wire logic signed [OFFSET_W-1:0]  req_offset,
   input  wire logic signed [COUNT_W-1:0]   req_byte_count,
   input  wire logic [WHENCE_W-1:0]         req_whence,
   // result out
   output logic                             rsp_valid,
   output logic [KIND_W-1:0]                rsp_request_kind,
   output logic                             rsp_disk,
   output logic [OUT_POS_W-1:0]             rsp_position,
   output logic [LEN_W-1:0]                 rsp_length
);

   localparam int FdW  = $clog2(FD_SLOTS);
   localparam int EntW = CTRL_W + FdW + POS_BITS + LEN_W;

   logic                accept;
   logic                push;
   op_ctrl_type         f_ctrl;
   logic [FdW-1:0]      f_fd;
   logic [POS_BITS-1:0] f_off;
   logic [LEN_W-1:0]    f_cnt;
   logic [EntW-1:0]     q_head;
   logic                q_empty, q_full, q_pop;
   logic                clearing;

   // busy while the table is swept or the queue has no room
   assign busy   = clearing || q_full;
   assign accept = start && !busy;

   // front: classify the call and fold the descriptor
   fdcr_front #(
      .FD_SLOTS (FD_SLOTS),
      .POS_BITS (POS_BITS)
   ) u_front (
      .accept         (accept),
      .req_mode       (req_mode),
      .req_descriptor (req_descriptor),
      .req_offset     (req_offset),
      .req_byte_count (req_byte_count),
      .req_whence     (req_whence),
      .push           (push),
      .ctrl           (f_ctrl),
      .fd             (f_fd),
      .off            (f_off),
      .cnt            (f_cnt)
   );

   // queue decouples front from back
   fdcr_queue #(
      .WIDTH (EntW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_ctrl, f_fd, f_off, f_cnt}),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // back: table read-modify-write, disk rotation, result register
   fdcr_back #(
      .FD_SLOTS (FD_SLOTS),
      .POS_BITS (POS_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_request_kind (rsp_request_kind),
      .rsp_disk         (rsp_disk),
      .rsp_position     (rsp_position),
      .rsp_length       (rsp_length)
   );

endmodule

`default_nettype wire

[rtl/core/fdcr_checker.sv]
`default_nettype none

module fdcr_checker
   import fdcr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 busy,
   input  wire logic                 rsp_valid,
   input  wire logic [KIND_W-1:0]    rsp_request_kind,
   input  wire logic                 rsp_disk,
   input  wire logic [OUT_POS_W-1:0] rsp_position,
   input  wire logic [LEN_W-1:0]     rsp_length
);

   logic exp_disk_ff, exp_disk_in;

   assign exp_disk_in = rsp_valid ? !exp_disk_ff : exp_disk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_disk_ff <= 1'b0;
      end else begin
         exp_disk_ff <= exp_disk_in;
      end
   end

   // table sweep holds the block off right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> busy)
      else $error("block not busy after reset");

   // back end returns to idle between items, so strobes never touch
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   // disks take turns, starting at disk 0
   a_disk_turns: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_disk == exp_disk_ff)
      else $error("disk rotation broken");

   // end of trace carries no position and no length
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_request_kind == KIND_END |-> rsp_position == '0 && rsp_length == '0)
      else $error("end request with payload");

endmodule

bind file_call_to_disk_request_top fdcr_checker u_fdcr_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_request_kind (rsp_request_kind),
   .rsp_disk         (rsp_disk),
   .rsp_position     (rsp_position),
   .rsp_length       (rsp_length)
);

`default_nettype wire
